### rtl/core/hsrd_pkg.sv
// Shared types and constants of the scanline RLE decoder core.
package hsrd_pkg;

    localparam int MAX_WIDTH = 32767;
    localparam int MIN_WIDTH = 8;

    // Descriptor queue between parser and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] MARK_BYTE = 8'd2;
    localparam logic [7:0] RUN_BASE  = 8'd128;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_RLE   = 2'd1,
        ST_BAD_WIDTH = 2'd2,
        ST_BAD_COUNT = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        PH_MARK0   = 8'b0000_0001,
        PH_MARK1   = 8'b0000_0010,
        PH_MARK2   = 8'b0000_0100,
        PH_MARK3   = 8'b0000_1000,
        PH_COUNT   = 8'b0001_0000,
        PH_RUNVAL  = 8'b0010_0000,
        PH_LITERAL = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_status     status;
        logic        is_run;
        logic [1:0]  channel;
        logic [14:0] position;
        logic [6:0]  run_length;
        logic [7:0]  value;
        logic        line_end;
    } t_desc;

    // Queue occupancy flags seen by the parser and the output stage
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

### rtl/core/hsrd_parse.sv
// Front end: marker and count parser that turns stream bytes into descriptors.
module hsrd_parse
    import hsrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_valid,
    input  logic [14:0] i_cfg_line_width,
    input  t_q_flags    i_q_flags,
    output logic        o_accept,
    output logic        o_q_push,
    output t_desc       o_q_desc
);

    t_phase      r_phase, n_phase;
    logic [14:0] r_line_width;
    logic [6:0]  r_width_high, n_width_high;
    logic [1:0]  r_plane, n_plane;
    logic [14:0] r_pixel_pos, n_pixel_pos;
    logic [7:0]  r_literal_left, n_literal_left;
    logic [6:0]  r_pending_run, n_pending_run;
    t_status     r_error_code, n_error_code;

    logic        accept;
    logic [14:0] pixels_left;
    logic [14:0] marker_width;
    logic [7:0]  lit_dec;
    logic        err_hit;
    t_status     err_code;
    logic        fill_hit;
    logic        fill_run;
    logic [6:0]  fill_n;
    logic [15:0] fill_sum;
    t_desc       desc;

    assign accept       = i_push && !i_q_flags.full;
    assign pixels_left  = (r_line_width > r_pixel_pos) ? (r_line_width - r_pixel_pos) : 15'd0;
    assign marker_width = {r_width_high, i_data_byte};
    assign lit_dec      = (r_literal_left != 8'd0) ? (r_literal_left - 8'd1) : 8'd0;
    assign fill_sum     = {1'b0, r_pixel_pos} + {9'd0, fill_n};

    always_comb begin
        n_phase        = r_phase;
        n_width_high   = r_width_high;
        n_plane        = r_plane;
        n_pixel_pos    = r_pixel_pos;
        n_literal_left = r_literal_left;
        n_pending_run  = r_pending_run;
        n_error_code   = r_error_code;
        err_hit        = 1'b0;
        err_code       = ST_OK;
        fill_hit       = 1'b0;
        fill_run       = 1'b0;
        fill_n         = 7'd1;
        desc           = '0;

        case (r_phase)
            PH_MARK0: begin
                if (i_data_byte != MARK_BYTE) begin
                    err_hit  = 1'b1;
                    err_code = ST_NOT_RLE;
                end else begin
                    n_phase = PH_MARK1;
                end
            end
            PH_MARK1: begin
                if (i_data_byte != MARK_BYTE) begin
                    err_hit  = 1'b1;
                    err_code = ST_NOT_RLE;
                end else begin
                    n_phase = PH_MARK2;
                end
            end
            PH_MARK2: begin
                if (i_data_byte[7]) begin
                    err_hit  = 1'b1;
                    err_code = ST_NOT_RLE;
                end else begin
                    n_width_high = i_data_byte[6:0];
                    n_phase      = PH_MARK3;
                end
            end
            PH_MARK3: begin
                if (marker_width != r_line_width || r_line_width < 15'(MIN_WIDTH)) begin
                    err_hit  = 1'b1;
                    err_code = ST_BAD_WIDTH;
                end else begin
                    n_plane        = 2'd0;
                    n_pixel_pos    = 15'd0;
                    n_literal_left = 8'd0;
                    n_pending_run  = 7'd0;
                    n_phase        = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_data_byte > RUN_BASE) begin
                    // count above 128 carries the run length in its low bits
                    if ({8'd0, i_data_byte[6:0]} > pixels_left) begin
                        err_hit  = 1'b1;
                        err_code = ST_BAD_COUNT;
                    end else begin
                        n_pending_run = i_data_byte[6:0];
                        n_phase       = PH_RUNVAL;
                    end
                end else if (i_data_byte == 8'd0 || {7'd0, i_data_byte} > pixels_left) begin
                    err_hit  = 1'b1;
                    err_code = ST_BAD_COUNT;
                end else begin
                    n_literal_left = i_data_byte;
                    n_phase        = PH_LITERAL;
                end
            end
            PH_RUNVAL: begin
                fill_hit = 1'b1;
                fill_run = 1'b1;
                fill_n   = r_pending_run;
            end
            PH_LITERAL: begin
                fill_hit       = 1'b1;
                n_literal_left = lit_dec;
            end
            PH_ERROR: begin
                err_hit  = 1'b1;
                err_code = r_error_code;
            end
            default: begin
                err_hit  = 1'b1;
                err_code = r_error_code;
            end
        endcase

        if (err_hit) begin
            n_phase      = PH_ERROR;
            n_error_code = err_code;
            desc.status  = err_code;
        end

        if (fill_hit) begin
            desc.status     = ST_OK;
            desc.is_run     = fill_run;
            desc.channel    = r_plane;
            desc.position   = r_pixel_pos;
            desc.run_length = fill_n;
            desc.value      = i_data_byte;
            if (fill_sum >= {1'b0, r_line_width}) begin
                // plane complete: drop any literal count left over
                n_pixel_pos    = 15'd0;
                n_literal_left = 8'd0;
                if (r_plane == 2'd3) begin
                    n_plane       = 2'd0;
                    desc.line_end = 1'b1;
                    n_phase       = PH_MARK0;
                end else begin
                    n_plane = r_plane + 2'd1;
                    n_phase = PH_COUNT;
                end
            end else begin
                n_pixel_pos = fill_sum[14:0];
                if (r_phase == PH_RUNVAL || lit_dec == 8'd0) begin
                    n_phase = PH_COUNT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_MARK0;
            r_line_width   <= 15'(MIN_WIDTH);
            r_width_high   <= 7'd0;
            r_plane        <= 2'd0;
            r_pixel_pos    <= 15'd0;
            r_literal_left <= 8'd0;
            r_pending_run  <= 7'd0;
            r_error_code   <= ST_OK;
        end else begin
            if (i_cfg_valid) begin
                r_line_width <= i_cfg_line_width;
            end
            if (accept) begin
                r_phase        <= n_phase;
                r_width_high   <= n_width_high;
                r_plane        <= n_plane;
                r_pixel_pos    <= n_pixel_pos;
                r_literal_left <= n_literal_left;
                r_pending_run  <= n_pending_run;
                r_error_code   <= n_error_code;
            end
        end
    end

    assign o_accept = accept;
    assign o_q_push = accept && (err_hit || fill_hit);
    assign o_q_desc = desc;

    // every byte taken after an error yields an error request with the stored code
    a_error_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_ERROR) |-> (o_q_push && o_q_desc.status == r_error_code
                                             && r_error_code != ST_OK))
        else $error("sticky error did not emit an error request");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR))
        else $error("error phase left without reset");

endmodule

### rtl/core/hsrd_fifo.sv
// Short descriptor queue between the parser and the output stage.
module hsrd_fifo
    import hsrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_desc    i_desc,
    input  logic     i_pop,
    output t_desc    o_head,
    output t_q_flags o_flags
);

    t_desc              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head        = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_flags.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == Q_CNT_W'(Q_DEPTH)))
        else $error("request pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

### rtl/core/hsrd_emit.sv
// Back end: output register that presents the oldest descriptor to the consumer.
module hsrd_emit
    import hsrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_desc    i_head,
    input  t_q_flags i_q_flags,
    output logic     o_q_pop,
    input  logic     i_pop,
    output logic     o_empty,
    output t_desc    o_desc
);

    logic  r_valid;
    t_desc r_desc;
    logic  load;

    // refill when the stage is free or its request leaves this cycle
    assign load    = !r_valid || i_pop;
    assign o_q_pop = load && !i_q_flags.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_flags.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_desc <= i_head;
        end
    end

    assign o_empty = !r_valid;
    assign o_desc  = r_desc;

endmodule

### rtl/core/hdr_scanline_rle_decoder_core.sv
// Top level of the RGBE scanline run-length decoder core.
//
//  channel   direction  handshake               payload
//  input     in         push / full             i_data_byte
//  result    out        empty / pop             o_status o_is_run o_channel o_position
//                                               o_run_length o_value o_line_end
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_line_width (always ready)
//
// One byte is taken per cycle while the queue is not full; the parser handles each byte in the cycle it is taken.
// A descriptor enters the queue at the edge that takes its byte and reaches the result
// ports through the output register, once that register is free or being popped.
// The input stalls only while the four-entry queue is full: pop held low until the
// output register and all queue entries are occupied.
// Synchronous active-low reset restores line width eight and clears the sticky error.
module hdr_scanline_rle_decoder_core
    import hsrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic        o_is_run,
    output logic [1:0]  o_channel,
    output logic [14:0] o_position,
    output logic [6:0]  o_run_length,
    output logic [7:0]  o_value,
    output logic        o_line_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_line_width
);

    t_q_flags q_flags;
    logic     q_push;
    t_desc    q_desc;
    logic     q_pop;
    t_desc    q_head;
    t_desc    out_desc;
    logic     accept;

    hsrd_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_data_byte      (i_data_byte),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_line_width (i_cfg_line_width),
        .i_q_flags        (q_flags),
        .o_accept         (accept),
        .o_q_push         (q_push),
        .o_q_desc         (q_desc)
    );

    hsrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_desc),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_flags (q_flags)
    );

    hsrd_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_flags (q_flags),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_desc    (out_desc)
    );

    assign full         = q_flags.full;
    assign o_cfg_ready  = 1'b1;
    assign o_status     = out_desc.status;
    assign o_is_run     = out_desc.is_run;
    assign o_channel    = out_desc.channel;
    assign o_position   = out_desc.position;
    assign o_run_length = out_desc.run_length;
    assign o_value      = out_desc.value;
    assign o_line_end   = out_desc.line_end;

    a_accept_matches_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept == (push && !full))
        else $error("parser accept differs from port handshake");

endmodule

### test/tb_hdr_scanline_rle_decoder_core.sv
// Self-checking testbench for the RGBE scanline RLE decoder core.
`timescale 1ns / 100ps

module tb_hdr_scanline_rle_decoder_core;
    import hsrd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic        o_is_run;
    logic [1:0]  o_channel;
    logic [14:0] o_position;
    logic [6:0]  o_run_length;
    logic [7:0]  o_value;
    logic        o_line_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_line_width = 15'd0;

    hdr_scanline_rle_decoder_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_is_run         (o_is_run),
        .o_channel        (o_channel),
        .o_position       (o_position),
        .o_run_length     (o_run_length),
        .o_value          (o_value),
        .o_line_end       (o_line_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_line_width (i_cfg_line_width)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Coded stream still to be sent, and descriptors still owed by the core
    logic [7:0] coded_bytes[$];
    t_desc      descs_due[$];
    int         gen_total = 0;

    int  snd_idle_pct = 0;
    int  rcv_idle_pct = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    bit  byte_took = 1'b0;
    bit  cfg_done = 1'b0;
    int  quiet_cycles = 0;
    int  mism_count = 0;

    // Decoder state as predicted; initial values equal the reset state
    int      mdl_width = 8;
    t_phase  mdl_phase = PH_MARK0;
    logic [6:0] mdl_wid_hi = '0;
    logic [1:0] mdl_plane = '0;
    int      mdl_pos = 0;
    int      mdl_lit_left = 0;
    int      mdl_run = 0;
    t_status mdl_err = ST_OK;

    function automatic int pixels_room();
        return (mdl_width > mdl_pos) ? mdl_width - mdl_pos : 0;
    endfunction

    task automatic flag_error(input t_status code);
        t_desc d;
        d = '0;
        d.status = code;
        mdl_err = code;
        mdl_phase = PH_ERROR;
        descs_due.push_back(d);
    endtask

    task automatic fill_pixels(input logic is_run, input int n, input logic [7:0] v);
        t_desc d;
        d = '0;
        d.status = ST_OK;
        d.is_run = is_run;
        d.channel = mdl_plane;
        d.position = mdl_pos[14:0];
        d.run_length = n[6:0];
        d.value = v;
        mdl_pos += n;
        if (mdl_pos >= mdl_width) begin
            // plane complete: drop whatever literal count is left
            mdl_pos = 0;
            mdl_lit_left = 0;
            if (mdl_plane == 2'd3) begin
                mdl_plane = 2'd0;
                d.line_end = 1'b1;
                mdl_phase = PH_MARK0;
            end else begin
                mdl_plane = mdl_plane + 2'd1;
                mdl_phase = PH_COUNT;
            end
        end else if (mdl_phase == PH_LITERAL && mdl_lit_left == 0) begin
            mdl_phase = PH_COUNT;
        end else if (mdl_phase == PH_RUNVAL) begin
            mdl_phase = PH_COUNT;
        end
        descs_due.push_back(d);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int wv;
        int n;
        case (mdl_phase)
            PH_MARK0: begin
                if (b != MARK_BYTE) flag_error(ST_NOT_RLE);
                else mdl_phase = PH_MARK1;
            end
            PH_MARK1: begin
                if (b != MARK_BYTE) flag_error(ST_NOT_RLE);
                else mdl_phase = PH_MARK2;
            end
            PH_MARK2: begin
                if (b[7]) begin
                    flag_error(ST_NOT_RLE);
                end else begin
                    mdl_wid_hi = b[6:0];
                    mdl_phase = PH_MARK3;
                end
            end
            PH_MARK3: begin
                wv = {mdl_wid_hi, b};
                if (wv != mdl_width || mdl_width < MIN_WIDTH || mdl_width > MAX_WIDTH) begin
                    flag_error(ST_BAD_WIDTH);
                end else begin
                    mdl_plane = 2'd0;
                    mdl_pos = 0;
                    mdl_lit_left = 0;
                    mdl_run = 0;
                    mdl_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (b > RUN_BASE) begin
                    n = int'(b) - int'(RUN_BASE);
                    if (n > pixels_room()) begin
                        flag_error(ST_BAD_COUNT);
                    end else begin
                        mdl_run = n;
                        mdl_phase = PH_RUNVAL;
                    end
                end else if (b == 8'd0 || int'(b) > pixels_room()) begin
                    flag_error(ST_BAD_COUNT);
                end else begin
                    mdl_lit_left = b;
                    mdl_phase = PH_LITERAL;
                end
            end
            PH_RUNVAL: fill_pixels(1'b1, mdl_run, b);
            PH_LITERAL: begin
                if (mdl_lit_left > 0) mdl_lit_left--;
                fill_pixels(1'b0, 1, b);
            end
            default: flag_error(mdl_err);
        endcase
    endtask

    // Sender: hold a request until it is taken, then offer the next byte
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || byte_took) begin
            if (coded_bytes.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                push <= 1'b1;
                i_data_byte <= coded_bytes.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold whenever one is requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_reqs) begin
            hold_seen++;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_desc seen;
        t_desc want;
        bit    took_desc;
        if (i_rst_n) begin
            cfg_done = i_cfg_valid && o_cfg_ready;
            if (cfg_done) mdl_width = i_cfg_line_width;
            took_desc = pop && !empty;
            if (took_desc) begin
                seen.status = t_status'(o_status);
                seen.is_run = o_is_run;
                seen.channel = o_channel;
                seen.position = o_position;
                seen.run_length = o_run_length;
                seen.value = o_value;
                seen.line_end = o_line_end;
                if (descs_due.size() == 0) begin
                    mism_count++;
                    if (mism_count <= MAX_REPORTS)
                        $display("%0t: descriptor with none expected: st=%0d pos=%0d",
                                 $realtime, seen.status, seen.position);
                end else begin
                    want = descs_due.pop_front();
                    if (seen !== want) begin
                        mism_count++;
                        if (mism_count <= MAX_REPORTS)
                            $display({"%0t: descriptor mismatch exp st=%0d run=%0d ch=%0d ",
                                      "pos=%0d len=%0d val=%0h end=%0d got st=%0d run=%0d ",
                                      "ch=%0d pos=%0d len=%0d val=%0h end=%0d"}, $realtime,
                                     want.status, want.is_run, want.channel, want.position,
                                     want.run_length, want.value, want.line_end,
                                     seen.status, seen.is_run, seen.channel, seen.position,
                                     seen.run_length, seen.value, seen.line_end);
                    end
                end
            end
            byte_took = push && !full;
            if (byte_took) decode_byte(i_data_byte);
            if (byte_took || cfg_done || took_desc) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic put(input int b);
        coded_bytes.push_back(b[7:0]);
        gen_total++;
    endtask

    task automatic add_marker(input int w);
        put(MARK_BYTE);
        put(MARK_BYTE);
        put((w >> 8) & 8'h7f);
        put(w & 8'hff);
    endtask

    // One plane of w pixels as a random mix of runs and literals
    task automatic add_plane(input int w);
        int  left;
        int  lim;
        int  n;
        bit  big;
        bit  tail;
        big = (w > 1000);
        tail = big || ($urandom_range(0, 3) == 0);
        left = tail ? w - 1 : w;
        while (left > 0) begin
            if (big ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 1) == 1)) begin
                lim = (left < 127) ? left : 127;
                if (big && lim > 96) n = $urandom_range(96, lim);
                else n = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, lim);
                put(RUN_BASE + n);
                put($urandom_range(0, 255));
            end else begin
                lim = (left < 128) ? left : 128;
                if (lim > 8 && $urandom_range(0, 7) != 0) lim = 8;
                n = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, lim);
                put(n);
                repeat (n) put($urandom_range(0, 255));
            end
            left -= n;
        end
        // finish on a single literal so the last pixel gets its own descriptor
        if (tail) begin
            put(1);
            put($urandom_range(0, 255));
        end
    endtask

    task automatic add_line(input int w);
        add_marker(w);
        repeat (4) add_plane(w);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (coded_bytes.size() != 0 || push || descs_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_width(input int w);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_line_width <= w[14:0];
        do @(negedge i_clk);
        while (!cfg_done);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int w_lo[6];
        int w_hi[6];
        int w;
        int bw;
        int k;
        int b;
        int n0;
        int sub;
        w_lo = '{8, 8, 100, 8, 8, 8};
        w_hi = '{24, 48, 300, 32, 64, 64};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset width: full run, a single literal, extreme values
        add_marker(8);
        put(RUN_BASE + 8); put(8'hff);
        put(1); put(8'h00); put(RUN_BASE + 7); put(8'haa);
        put(RUN_BASE + 8); put(8'h80);
        put(RUN_BASE + 8); put(8'h01);
        wait_idle();

        // Shrink the width in the middle of a literal: the plane ends, the rest is dropped
        write_width(16);
        add_marker(16);
        put(RUN_BASE + 7); put(8'h33);
        put(5);
        wait_idle();
        write_width(8);
        put(8'h22);
        repeat (3) add_plane(8);

        for (sub = 0; sub < 6; sub++) begin
            case (sub / 2)
                0: begin snd_idle_pct = 24; rcv_idle_pct = 85; end
                1: begin snd_idle_pct = 85; rcv_idle_pct = 24; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            wait_idle();
            write_width($urandom_range(w_lo[sub], w_hi[sub]));
            n0 = gen_total;
            while (gen_total - n0 < 20) add_line(mdl_width);
            // hold the receiver off while the sender keeps offering bytes
            if (sub == 4) hold_reqs++;
        end

        // Widest line: one full plane, then narrow the width for the rest of the line
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        wait_idle();
        write_width(MAX_WIDTH);
        add_marker(MAX_WIDTH);
        add_plane(MAX_WIDTH);
        wait_idle();
        w = $urandom_range(8, 16);
        write_width(w);
        repeat (3) add_plane(w);

        // Finish on an error, which stays until reset
        wait_idle();
        w = $urandom_range(8, 40);
        write_width(w);
        add_line(w);
        k = $urandom_range(0, 5);
        case (k)
            0: begin
                b = $urandom_range(0, 254);
                put((b >= MARK_BYTE) ? b + 1 : b);
            end
            1: begin
                b = $urandom_range(0, 254);
                put(MARK_BYTE);
                put((b >= MARK_BYTE) ? b + 1 : b);
            end
            2: begin
                put(MARK_BYTE);
                put(MARK_BYTE);
                put($urandom_range(128, 255));
            end
            3: begin
                bw = $urandom_range(MIN_WIDTH, MAX_WIDTH);
                add_marker((bw == w) ? w + 1 : bw);
            end
            4: begin
                wait_idle();
                bw = $urandom_range(0, MIN_WIDTH - 1);
                write_width(bw);
                add_marker(bw);
            end
            default: begin
                add_marker(w);
                put(RUN_BASE + 1);
                put($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0: put(0);
                    1: put(RUN_BASE);
                    2: put(w);
                    default: put(RUN_BASE + w);
                endcase
            end
        endcase
        repeat (20) put($urandom_range(0, 255));

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mism_count == 0 && descs_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
